// ===== sv/uvpb_pkg.sv =====
// Shared types, register map and reset values for the undervoltage element.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package uvpb_pkg;

    localparam int unsigned CntW   = 16;
    localparam int unsigned LevelW = 16;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned DataW  = 32;

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] RegBlockLevel   = 3'd0;
    localparam logic [2:0] RegPickupLevel  = 3'd1;
    localparam logic [2:0] RegResetLevel   = 3'd2;
    localparam logic [2:0] RegTripDelay    = 3'd3;
    localparam logic [2:0] RegResetDelay   = 3'd4;
    localparam logic [2:0] RegStartGate    = 3'd5;
    localparam logic [2:0] RegBlockRelease = 3'd6;

    localparam logic [LevelW-1:0] RstBlockLevel   = 16'd6554;
    localparam logic [LevelW-1:0] RstPickupLevel  = 16'd52429;
    localparam logic [LevelW-1:0] RstResetLevel   = 16'd55706;
    localparam logic [CntW-1:0]   RstTripDelay    = 16'd1000;
    localparam logic [CntW-1:0]   RstResetDelay   = 16'd100;
    localparam logic [CntW-1:0]   RstStartGate    = 16'd0;
    localparam logic [CntW-1:0]   RstBlockRelease = 16'd30;

    typedef struct packed {
        logic [LevelW-1:0] block_level;
        logic [LevelW-1:0] pickup_level;
        logic [LevelW-1:0] reset_level;
        logic [CntW-1:0]   trip_delay;
        logic [CntW-1:0]   reset_delay;
        logic [CntW-1:0]   start_gate;
        logic [CntW-1:0]   block_release;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic trip;
    } t_flags;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CntMax) ? CntMax : v + 1'b1;
    endfunction

endpackage

// ===== sv/uvpb_regs.sv =====
// APB-style settings registers for the undervoltage element.
// Depends on uvpb_pkg (t_cfg, register indexes, reset values).
`timescale 1ns / 1ps

module uvpb_regs
    import uvpb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [15:0] wdata;
    logic [15:0] rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign wdata   = pwdata[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_level   <= RstBlockLevel;
            r_cfg.pickup_level  <= RstPickupLevel;
            r_cfg.reset_level   <= RstResetLevel;
            r_cfg.trip_delay    <= RstTripDelay;
            r_cfg.reset_delay   <= RstResetDelay;
            r_cfg.start_gate    <= RstStartGate;
            r_cfg.block_release <= RstBlockRelease;
        end else if (wr_en) begin
            unique case (reg_idx)
                RegBlockLevel:   r_cfg.block_level   <= wdata;
                RegPickupLevel:  r_cfg.pickup_level  <= wdata;
                RegResetLevel:   r_cfg.reset_level   <= wdata;
                RegTripDelay:    r_cfg.trip_delay    <= wdata;
                RegResetDelay:   r_cfg.reset_delay   <= wdata;
                RegStartGate:    r_cfg.start_gate    <= wdata;
                RegBlockRelease: r_cfg.block_release <= wdata;
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegBlockLevel:   rdata = r_cfg.block_level;
            RegPickupLevel:  rdata = r_cfg.pickup_level;
            RegResetLevel:   rdata = r_cfg.reset_level;
            RegTripDelay:    rdata = r_cfg.trip_delay;
            RegResetDelay:   rdata = r_cfg.reset_delay;
            RegStartGate:    rdata = r_cfg.start_gate;
            RegBlockRelease: rdata = r_cfg.block_release;
            default:         rdata = '0;
        endcase
    end

    assign prdata = {{(DataW-16){1'b0}}, rdata};
    assign o_cfg  = r_cfg;

endmodule

// ===== sv/uvpb_core.sv =====
// Element state (trip, reset and block counters, start/trip) and its per-tick update.
// Depends on uvpb_pkg (t_cfg, t_flags, sat_inc).
`timescale 1ns / 1ps

module uvpb_core
    import uvpb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic [LevelW-1:0] i_voltage,
    input  t_cfg              i_cfg,
    output t_flags            o_flags
);

    logic [CntW-1:0] r_trip_cnt, n_trip_cnt;
    logic [CntW-1:0] r_rst_cnt,  n_rst_cnt;
    logic [CntW-1:0] r_blk_cnt,  n_blk_cnt;
    logic            r_start,    n_start;
    logic            r_trip,     n_trip;

    logic [CntW-1:0] trip_inc;
    logic [CntW-1:0] rst_inc;
    logic [CntW-1:0] blk_inc;

    assign trip_inc = (r_trip_cnt < i_cfg.trip_delay) ? r_trip_cnt + 1'b1 : r_trip_cnt;
    assign rst_inc  = sat_inc(r_rst_cnt);
    assign blk_inc  = sat_inc(r_blk_cnt);

    always_comb begin
        n_trip_cnt = r_trip_cnt;
        n_rst_cnt  = r_rst_cnt;
        n_blk_cnt  = r_blk_cnt;
        n_start    = r_start;
        n_trip     = r_trip;
        if (i_voltage > i_cfg.block_level) begin
            n_blk_cnt = '0;
            if (i_voltage <= i_cfg.pickup_level) begin
                // pickup: start gate tested on the count before this tick
                if (r_trip_cnt > i_cfg.start_gate) begin
                    n_start = 1'b1;
                end
                n_rst_cnt = '0;
                if (trip_inc >= i_cfg.trip_delay) begin
                    n_trip_cnt = i_cfg.trip_delay;
                    n_trip     = 1'b1;
                end else begin
                    n_trip_cnt = trip_inc;
                end
            end else if ((i_voltage > i_cfg.reset_level) && (r_trip_cnt != '0)) begin
                n_start = 1'b0;
                if (rst_inc >= i_cfg.reset_delay) begin
                    n_trip_cnt = '0;
                    n_rst_cnt  = '0;
                    n_trip     = 1'b0;
                end else begin
                    n_rst_cnt = rst_inc;
                end
            end
        end else begin
            if (blk_inc >= i_cfg.block_release) begin
                n_trip_cnt = '0;
                n_rst_cnt  = '0;
                n_blk_cnt  = '0;
                n_start    = 1'b0;
                n_trip     = 1'b0;
            end else begin
                n_blk_cnt = blk_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip_cnt <= '0;
            r_rst_cnt  <= '0;
            r_blk_cnt  <= '0;
            r_start    <= 1'b0;
            r_trip     <= 1'b0;
        end else if (i_tick) begin
            r_trip_cnt <= n_trip_cnt;
            r_rst_cnt  <= n_rst_cnt;
            r_blk_cnt  <= n_blk_cnt;
            r_start    <= n_start;
            r_trip     <= n_trip;
        end
    end

    assign o_flags.start = n_start;
    assign o_flags.trip  = n_trip;

endmodule

// ===== sv/undervoltage_protection_with_block_unit.sv =====
// Top level of the definite-time undervoltage element with low-voltage blocking.
// Depends on uvpb_pkg, uvpb_regs and uvpb_core.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  in       | into      | i_in_valid / o_in_stall  | i_voltage[15:0]
//  out      | out of    | o_out_valid / i_out_stall| o_start_flag, o_trip_flag
//  apb      | into      | psel/penable/pready      | paddr[4:0], pwdata, prdata
//
//  One word per clock unless the result side stalls; path: input register, then
//  state update and result register. Synchronous active-low reset clears counters,
//  flags and the valid bits; settings return to their default levels and delays.
//  A stall on the result side holds the result register; the input register
//  keeps taking a word whenever the result register is free or being drained.

module undervoltage_protection_with_block_unit
    import uvpb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample in
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [LevelW-1:0] i_voltage,
    // flags out
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_start_flag,
    output logic              o_trip_flag,
    // settings port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready
);

    t_cfg              cfg;
    t_flags            flags;

    logic              r_in_valid;
    logic [LevelW-1:0] r_in_voltage;
    logic              r_out_valid;
    t_flags            r_out_flags;

    logic              out_free;   // result register empty or being taken
    logic              advance;    // input word moves into the state update
    logic              in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    uvpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    uvpb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (advance),
        .i_voltage (r_in_voltage),
        .i_cfg     (cfg),
        .o_flags   (flags)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_voltage <= i_voltage;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_flags <= flags;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_start_flag = r_out_flags.start;
    assign o_trip_flag  = r_out_flags.trip;

    // a word held in the input register does not move while the result side is full
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_voltage)))
        else $error("input word lost or changed while held");

    // every word that enters the state update yields a result
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && (r_out_flags == $past(flags))))
        else $error("updated flags not loaded into result register");

    // a stalled result is never overwritten
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !advance)
        else $error("stalled result overwritten");

endmodule

// ===== bench/uvpb_flag_checker.sv =====
`timescale 1ns / 1ps
// Flag checker for the undervoltage element: follows settings writes on the APB port,
// predicts the start/trip flags of every accepted sample word and compares the results.
// Depends on uvpb_pkg.

module uvpb_flag_checker
    import uvpb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [LevelW-1:0] i_voltage,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_start_flag,
    input  logic              i_trip_flag,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [AddrW-1:0]  i_paddr,
    input  logic [DataW-1:0]  i_pwdata,
    output int                o_fails,
    output int                o_pending,
    output int                o_checked
);

    t_cfg            cfg;
    logic [CntW-1:0] trip_cnt;
    logic [CntW-1:0] rst_cnt;
    logic [CntW-1:0] blk_cnt;
    logic            start_q;
    logic            trip_q;
    t_flags          flags_due[$];

    initial begin
        o_fails   = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic drop_out();
        trip_cnt = '0;
        rst_cnt  = '0;
        blk_cnt  = '0;
        start_q  = 1'b0;
        trip_q   = 1'b0;
    endtask

    // one protection tick; queues the flags it leaves behind
    task automatic relay_tick(input logic [LevelW-1:0] v);
        t_flags f;
        if (v > cfg.block_level) begin
            if (v <= cfg.pickup_level) begin
                if (trip_cnt > cfg.start_gate) start_q = 1'b1;
                rst_cnt = '0;
                if (trip_cnt < cfg.trip_delay) trip_cnt = trip_cnt + 1'b1;
                if (trip_cnt >= cfg.trip_delay) begin
                    trip_cnt = cfg.trip_delay;
                    trip_q   = 1'b1;
                end
            end else if (v > cfg.reset_level && trip_cnt != '0) begin
                start_q = 1'b0;
                if (rst_cnt != CntMax) rst_cnt = rst_cnt + 1'b1;
                if (rst_cnt >= cfg.reset_delay) begin
                    trip_cnt = '0;
                    rst_cnt  = '0;
                    trip_q   = 1'b0;
                end
            end
            blk_cnt = '0;
        end else begin
            if (blk_cnt != CntMax) blk_cnt = blk_cnt + 1'b1;
            if (blk_cnt >= cfg.block_release) drop_out();
        end
        f.start = start_q;
        f.trip  = trip_q;
        flags_due.push_back(f);
    endtask

    always @(posedge i_clk) begin
        t_flags got;
        t_flags want;
        if (!i_rst_n) begin
            cfg = '{block_level: RstBlockLevel, pickup_level: RstPickupLevel,
                    reset_level: RstResetLevel, trip_delay: RstTripDelay,
                    reset_delay: RstResetDelay, start_gate: RstStartGate,
                    block_release: RstBlockRelease};
            drop_out();
            flags_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[AddrW-1:2])
                    RegBlockLevel:   cfg.block_level   = i_pwdata[LevelW-1:0];
                    RegPickupLevel:  cfg.pickup_level  = i_pwdata[LevelW-1:0];
                    RegResetLevel:   cfg.reset_level   = i_pwdata[LevelW-1:0];
                    RegTripDelay:    cfg.trip_delay    = i_pwdata[CntW-1:0];
                    RegResetDelay:   cfg.reset_delay   = i_pwdata[CntW-1:0];
                    RegStartGate:    cfg.start_gate    = i_pwdata[CntW-1:0];
                    RegBlockRelease: cfg.block_release = i_pwdata[CntW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) relay_tick(i_voltage);
            if (i_out_valid && !i_out_stall) begin
                got.start = i_start_flag;
                got.trip  = i_trip_flag;
                if (flags_due.size() == 0) begin
                    o_fails++;
                    $display("%0t: flags word with none expected (start %b, trip %b)",
                             $time, got.start, got.trip);
                end else begin
                    want = flags_due.pop_front();
                    o_checked++;
                    if (got.start !== want.start) begin
                        o_fails++;
                        $display("%0t: start flag expected %b, got %b",
                                 $time, want.start, got.start);
                    end
                    if (got.trip !== want.trip) begin
                        o_fails++;
                        $display("%0t: trip flag expected %b, got %b",
                                 $time, want.trip, got.trip);
                    end
                end
            end
        end
        o_pending = flags_due.size();
    end

endmodule

// ===== bench/tb_undervoltage_protection_with_block_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the undervoltage element: clock, reset, sample and settings stimulus,
// result-side stalls and the verdict. Depends on uvpb_pkg, the block and uvpb_flag_checker.

module tb_undervoltage_protection_with_block_unit;
    import uvpb_pkg::*;

    // one past the last register: writes here must leave every setting alone
    localparam logic [2:0] RegUnmapped = 3'd7;

    // voltage bands relative to the current levels, used to build runs of samples
    typedef enum int {ZoneBlocked, ZonePickup, ZoneBand, ZoneReset, ZoneNoise} t_zone;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [LevelW-1:0] i_voltage = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_start_flag;
    logic              o_trip_flag;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [AddrW-1:0]  paddr = '0;
    logic [DataW-1:0]  pwdata = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;

    int   fails;
    int   pending;
    int   checked;
    int   in_gap_pct = 0;       // chance of a gap before each sample word
    int   out_stall_pct = 0;    // chance of a stall burst on the result side
    int   stall_left = 0;
    int   sent = 0;
    int   settings = 0;
    t_cfg cur_cfg;              // settings in force, used to aim the random voltages and size the runs

    always #10 i_clk = ~i_clk;

    undervoltage_protection_with_block_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_voltage    (i_voltage),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_start_flag (o_start_flag),
        .o_trip_flag  (o_trip_flag),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    uvpb_flag_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_voltage    (i_voltage),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_start_flag (o_start_flag),
        .i_trip_flag  (o_trip_flag),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // gap and stall lengths: drawn from three ranges, the shortest most often, the longest rarely
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(8, 4);
        return $urandom_range(40, 10);
    endfunction

    // result side: stall bursts of random length, none at all when the knob is zero
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(99) < out_stall_pct) begin
            stall_left = gap_len();
        end
        i_out_stall <= (stall_left > 0);
    end

    // Called at a rising edge. Valid stays high on return so that a following word
    // with no gap goes out back to back; settle() lowers it.
    task automatic send_sample(input logic [LevelW-1:0] v);
        int gap;
        gap = ($urandom_range(99) < in_gap_pct) ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_voltage  <= v;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // setup then access cycle; upper data bits are junk the block must ignore
    task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input t_cfg c);
        reg_write(RegBlockLevel,   c.block_level);
        reg_write(RegPickupLevel,  c.pickup_level);
        reg_write(RegResetLevel,   c.reset_level);
        reg_write(RegTripDelay,    c.trip_delay);
        reg_write(RegResetDelay,   c.reset_delay);
        reg_write(RegStartGate,    c.start_gate);
        reg_write(RegBlockRelease, c.block_release);
        cur_cfg = c;
        settings++;
    endtask

    // Stop sending and wait for every outstanding flags word. Counts are sampled on
    // the falling edge so they never race the checker; a further wait covers the
    // two-stage pipe before returning on a rising edge.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(2))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // flavours: ordered levels, pickup overlapping reset, anything goes, extremes
    function automatic t_cfg random_config(input int flavour);
        t_cfg c;
        int   b;
        int   p;
        c.trip_delay    = 16'($urandom_range(12, 1));
        c.reset_delay   = 16'($urandom_range(12, 1));
        c.block_release = 16'($urandom_range(12, 1));
        c.start_gate    = 16'($urandom_range(int'(c.trip_delay) + 2));
        case (flavour)
            0: begin
                b = $urandom_range(20000);
                p = b + $urandom_range(20000);
                c.block_level  = 16'(b);
                c.pickup_level = 16'(p);
                c.reset_level  = 16'(p + $urandom_range(20000));
            end
            1: begin
                b = $urandom_range(20000);
                p = b + $urandom_range(20000);
                c.block_level  = 16'(b);
                c.reset_level  = 16'(p);
                c.pickup_level = 16'(p + $urandom_range(20000));
            end
            2: begin
                c.block_level  = 16'($urandom_range(16'hFFFF));
                c.pickup_level = 16'($urandom_range(16'hFFFF));
                c.reset_level  = 16'($urandom_range(16'hFFFF));
                c.start_gate   = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(3) == 0) c.trip_delay    = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(3) == 0) c.reset_delay   = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(3) == 0) c.block_release = 16'($urandom_range(16'hFFFF));
            end
            default: begin
                c.block_level  = pick_extreme();
                c.pickup_level = pick_extreme();
                c.reset_level  = pick_extreme();
                c.start_gate   = pick_extreme();
                if ($urandom_range(1)) c.trip_delay    = pick_extreme();
                else                   c.trip_delay    = 16'($urandom_range(3));
                if ($urandom_range(1)) c.reset_delay   = pick_extreme();
                else                   c.reset_delay   = 16'($urandom_range(3));
                if ($urandom_range(1)) c.block_release = pick_extreme();
                else                   c.block_release = 16'($urandom_range(3));
            end
        endcase
        return c;
    endfunction

    // a voltage inside the chosen band, or anywhere when the band is empty
    function automatic logic [15:0] zone_voltage(input t_zone z);
        int b;
        int p;
        int r;
        int lo;
        int hi;
        b  = int'(cur_cfg.block_level);
        p  = int'(cur_cfg.pickup_level);
        r  = int'(cur_cfg.reset_level);
        lo = 0;
        hi = 65535;
        case (z)
            ZoneBlocked: hi = b;
            ZonePickup: begin
                lo = b + 1;
                hi = p;
            end
            ZoneBand: begin
                lo = ((b > p) ? b : p) + 1;
                hi = r;
            end
            ZoneReset: begin
                lo = (b > p) ? b : p;
                lo = ((lo > r) ? lo : r) + 1;
            end
            default: ;
        endcase
        if (lo > hi) begin
            lo = 0;
            hi = 65535;
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    // run lengths that can reach the delay in force, capped to keep phases short
    function automatic int run_len(input t_zone z);
        int cap;
        case (z)
            ZonePickup:  cap = int'(cur_cfg.trip_delay) + 3;
            ZoneReset:   cap = int'(cur_cfg.reset_delay) + 2;
            ZoneBlocked: cap = int'(cur_cfg.block_release) + 2;
            ZoneBand:    cap = 5;
            default:     cap = 3;
        endcase
        if (cap > 40) cap = 40;
        return $urandom_range(cap, 1);
    endfunction

    initial begin
        t_cfg  c;
        t_zone z;
        int    phase;
        int    issued;
        int    n;
        int    r;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_cfg = '{block_level: RstBlockLevel, pickup_level: RstPickupLevel,
                    reset_level: RstResetLevel, trip_delay: RstTripDelay,
                    reset_delay: RstResetDelay, start_gate: RstStartGate,
                    block_release: RstBlockRelease};
        in_gap_pct    = 20;
        out_stall_pct = 20;

        // default settings: both ends of the voltage range and each level edge
        send_sample(16'h0000);
        send_sample(16'hFFFF);        // above reset with nothing counted: no effect
        send_sample(RstBlockLevel);   // exactly on the block level is blocked
        send_sample(RstBlockLevel + 16'd1);
        send_sample(RstPickupLevel);  // exactly on pickup still picks up
        send_sample(RstPickupLevel + 16'd1);
        send_sample(RstResetLevel);   // top of the hysteresis band
        send_sample(RstResetLevel + 16'd1);

        // short delays: start past the gate, trip, clear by reset, clear by blocking;
        // a write past the register map goes in too
        settle();
        c = '{block_level: 16'd100, pickup_level: 16'd1000, reset_level: 16'd2000,
              trip_delay: 16'd3, reset_delay: 16'd2, start_gate: 16'd1,
              block_release: 16'd2};
        write_config(c);
        reg_write(RegUnmapped, 16'hBEEF);
        repeat (4) send_sample(16'd500);
        repeat (2) send_sample(16'd3000);
        send_sample(16'd1500);
        repeat (2) send_sample(16'd500);
        repeat (2) send_sample(16'd50);

        // trip delay cut below the running count: clamps and trips on the next pickup
        settle();
        reg_write(RegTripDelay, 16'd10);
        repeat (4) send_sample(16'd500);
        settle();
        reg_write(RegTripDelay, 16'd2);
        send_sample(16'd500);

        // zero delays, and pickup level equal to reset level so pickup takes priority
        settle();
        reg_write(RegTripDelay, 16'd0);
        reg_write(RegResetDelay, 16'd0);
        reg_write(RegBlockRelease, 16'd0);
        reg_write(RegPickupLevel, 16'd40000);
        reg_write(RegResetLevel, 16'd40000);
        send_sample(16'd40000);
        send_sample(16'hFFFF);
        send_sample(16'd50);          // first blocked tick clears everything
        send_sample(16'd500);         // trips at once, count stays at zero

        // random phases: mostly runs inside one band, some noise; counts carry over
        // from phase to phase, so fresh delays often land below a running count
        for (phase = 0; phase < 14; phase++) begin
            settle();
            write_config(random_config(phase % 4));
            in_gap_pct    = (phase % 5 == 0) ? 0 : $urandom_range(60, 10);
            out_stall_pct = (phase % 5 == 0) ? 0 : $urandom_range(50, 5);
            issued = 0;
            while (issued < 125) begin
                r = $urandom_range(99);
                z = (r < 35) ? ZonePickup  :
                    (r < 60) ? ZoneReset   :
                    (r < 75) ? ZoneBlocked :
                    (r < 85) ? ZoneBand    : ZoneNoise;
                n = run_len(z);
                repeat (n) begin
                    send_sample(zone_voltage(z));
                    issued++;
                end
            end
        end

        settle();
        $display("Sent %0d voltage words under %0d settings sets, with gaps and stalls.",
                 sent, settings);
        $display("Compared %0d flag words against the predicted start and trip.", checked);
        if (fails == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
